[hdl/sem_pkg.sv]
package sem_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int EW_W         = COL_W + 1;
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int CH_W         = 8;
    localparam int NUM_CH       = 3;
    localparam int PIX_W        = CH_W * NUM_CH;
    localparam int GRAD_W       = CH_W + 2;
    localparam int SQ_W         = 2 * GRAD_W;
    localparam int MAG_W        = SQ_W + 1;
    localparam int ROOT_STEP_W  = $clog2(CH_W);
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // One classified slot handed from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic             col_zero;
        logic             have;
        logic             top_ok;
        logic             bot_ok;
        logic             last;
    } slot_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GRAD,
        BK_SQ,
        BK_SUM,
        BK_ROOT,
        BK_OUT
    } back_state_t;

endpackage

[hdl/sobel_edge_magnitude_rgb.sv]
// Sobel edge magnitude over an RGB raster stream with a zero border. Send each frame's
// pixels in raster order followed by frame_width+1 flush beats; the result for pixel k
// leaves after input beat k+frame_width+1, with m_frame_last on the final pixel. Each
// beat takes the line store read and gradient steps of the back end; one that yields a
// result also takes squares, sum, root iterations in the bit-per-cycle root unit of each
// channel and output load, and waits to load while the receiver still holds the output
// register. A 4-beat queue decouples input from the back end, and the output register
// lets the next beat proceed while a result waits.
// Configuration writes restart the frame and must be issued only while the block is idle.
module sobel_edge_magnitude_rgb (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [sem_pkg::CH_W-1:0]       s_blue_in,
    input  logic [sem_pkg::CH_W-1:0]       s_green_in,
    input  logic [sem_pkg::CH_W-1:0]       s_red_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sem_pkg::CH_W-1:0]       m_blue_edge,
    output logic [sem_pkg::CH_W-1:0]       m_green_edge,
    output logic [sem_pkg::CH_W-1:0]       m_red_edge,
    output logic                           m_frame_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

    sem_pkg::slot_t push_data, pop_data;
    logic           push, pop, full, empty, cfg_clear;

    sem_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_blue_in  (s_blue_in),
        .s_green_in (s_green_in),
        .s_red_in   (s_red_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg_clear  (cfg_clear),
        .q_push     (push),
        .q_data     (push_data),
        .q_full     (full)
    );

    sem_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    sem_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_clear    (cfg_clear),
        .q_empty      (empty),
        .q_data       (pop_data),
        .q_pop        (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_blue_edge  (m_blue_edge),
        .m_green_edge (m_green_edge),
        .m_red_edge   (m_red_edge),
        .m_frame_last (m_frame_last)
    );

endmodule

[hdl/sem_front.sv]
module sem_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [sem_pkg::CH_W-1:0]       s_blue_in,
    input  logic [sem_pkg::CH_W-1:0]       s_green_in,
    input  logic [sem_pkg::CH_W-1:0]       s_red_in,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           cfg_clear,
    output logic                           q_push,
    output sem_pkg::slot_t                 q_data,
    input  logic                           q_full
);

    logic [sem_pkg::WIDTH_W-1:0]  frame_width_reg;
    logic [sem_pkg::HEIGHT_W-1:0] frame_height_reg;
    logic [sem_pkg::COL_W-1:0]    col_reg, col_next;
    logic [sem_pkg::HEIGHT_W-1:0] row_reg, row_next;
    logic [sem_pkg::EW_W-1:0]     w_eff, cx;
    logic [sem_pkg::HEIGHT_W-1:0] h_eff, cy;
    logic                         have, last;

    assign cfg_ready = 1'b1;
    assign cfg_clear = cfg_valid && (cfg_index == sem_pkg::REG_FRAME_WIDTH ||
                                     cfg_index == sem_pkg::REG_FRAME_HEIGHT);
    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = sem_pkg::EW_W'(1);
        end else if (32'(frame_width_reg) > sem_pkg::MAX_WIDTH) begin
            w_eff = sem_pkg::EW_W'(sem_pkg::MAX_WIDTH);
        end else begin
            w_eff = sem_pkg::EW_W'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = sem_pkg::HEIGHT_W'(1);
        end else if (32'(frame_height_reg) > sem_pkg::HEIGHT_LIMIT) begin
            h_eff = sem_pkg::HEIGHT_W'(sem_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = frame_height_reg;
        end

        if (col_reg == '0) begin
            // finishes the last pixel of the row before
            have = (row_reg >= sem_pkg::HEIGHT_W'(2)) &&
                   ((row_reg - sem_pkg::HEIGHT_W'(2)) < h_eff);
            cy   = row_reg - sem_pkg::HEIGHT_W'(2);
            cx   = w_eff - sem_pkg::EW_W'(1);
        end else begin
            have = (row_reg >= sem_pkg::HEIGHT_W'(1)) &&
                   ((row_reg - sem_pkg::HEIGHT_W'(1)) < h_eff);
            cy   = row_reg - sem_pkg::HEIGHT_W'(1);
            cx   = sem_pkg::EW_W'(col_reg) - sem_pkg::EW_W'(1);
        end
        last = have && (cy == h_eff - sem_pkg::HEIGHT_W'(1)) &&
               (cx == w_eff - sem_pkg::EW_W'(1));

        q_data.pix      = s_kind ? '0 : {s_red_in, s_green_in, s_blue_in};
        q_data.col      = col_reg;
        q_data.col_zero = (col_reg == '0);
        q_data.have     = have;
        q_data.top_ok   = (cy != '0);
        q_data.bot_ok   = ((sem_pkg::HEIGHT_W + 1)'(cy) + 1'b1) <
                          (sem_pkg::HEIGHT_W + 1)'(h_eff);
        q_data.last     = last;

        if (last) begin
            col_next = '0;
            row_next = '0;
        end else if ((sem_pkg::EW_W'(col_reg) + sem_pkg::EW_W'(1)) >= w_eff) begin
            col_next = '0;
            row_next = row_reg + sem_pkg::HEIGHT_W'(1);
        end else begin
            col_next = col_reg + sem_pkg::COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= sem_pkg::WIDTH_W'(640);
            frame_height_reg <= sem_pkg::HEIGHT_W'(480);
            col_reg          <= '0;
            row_reg          <= '0;
        end else if (cfg_clear) begin
            if (cfg_index == sem_pkg::REG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_data[sem_pkg::WIDTH_W-1:0];
            end else begin
                frame_height_reg <= cfg_data[sem_pkg::HEIGHT_W-1:0];
            end
            col_reg <= '0;
            row_reg <= '0;
        end else if (q_push) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[hdl/sem_fifo.sv]
module sem_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sem_pkg::slot_t push_data,
    output logic           full,
    input  logic           pop,
    output sem_pkg::slot_t pop_data,
    output logic           empty
);

    sem_pkg::slot_t               mem [sem_pkg::QDEPTH];
    logic [sem_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [sem_pkg::QPTR_W:0]     count_reg;

    assign full     = (count_reg == (sem_pkg::QPTR_W + 1)'(sem_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/sem_back.sv]
module sem_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_clear,
    input  logic                     q_empty,
    input  sem_pkg::slot_t           q_data,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [sem_pkg::CH_W-1:0] m_blue_edge,
    output logic [sem_pkg::CH_W-1:0] m_green_edge,
    output logic [sem_pkg::CH_W-1:0] m_red_edge,
    output logic                     m_frame_last
);

    sem_pkg::back_state_t state_reg, state_next;
    sem_pkg::slot_t       cur_reg;

    logic [sem_pkg::PIX_W-1:0] bank0 [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] bank1 [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] up2_reg, up1_reg;

    logic [sem_pkg::PIX_W-1:0] win_reg [3][3];
    logic [sem_pkg::PIX_W-1:0] sh [3][3];
    logic [sem_pkg::PIX_W-1:0] new_col [3];

    logic [sem_pkg::CH_W-1:0]   p [sem_pkg::NUM_CH][3][3];
    logic [sem_pkg::GRAD_W-1:0] pos_x [sem_pkg::NUM_CH];
    logic [sem_pkg::GRAD_W-1:0] neg_x [sem_pkg::NUM_CH];
    logic [sem_pkg::GRAD_W-1:0] pos_y [sem_pkg::NUM_CH];
    logic [sem_pkg::GRAD_W-1:0] neg_y [sem_pkg::NUM_CH];
    logic [sem_pkg::GRAD_W-1:0] ax_reg [sem_pkg::NUM_CH];
    logic [sem_pkg::GRAD_W-1:0] ay_reg [sem_pkg::NUM_CH];
    logic [sem_pkg::SQ_W-1:0]   sqx_reg [sem_pkg::NUM_CH];
    logic [sem_pkg::SQ_W-1:0]   sqy_reg [sem_pkg::NUM_CH];
    logic [sem_pkg::MAG_W-1:0]  n_reg [sem_pkg::NUM_CH];
    logic [sem_pkg::CH_W-1:0]   root_reg [sem_pkg::NUM_CH];
    logic [sem_pkg::CH_W-1:0]   root_next [sem_pkg::NUM_CH];
    logic [sem_pkg::CH_W-1:0]   trial [sem_pkg::NUM_CH];
    logic [2*sem_pkg::CH_W-1:0] trial_sq [sem_pkg::NUM_CH];
    logic [sem_pkg::ROOT_STEP_W-1:0] step_reg;

    logic                     m_valid_reg;
    logic [sem_pkg::CH_W-1:0] m_blue_reg, m_green_reg, m_red_reg;
    logic                     m_last_reg;
    logic                     out_load;

    assign m_valid      = m_valid_reg;
    assign m_blue_edge  = m_blue_reg;
    assign m_green_edge = m_green_reg;
    assign m_red_edge   = m_red_reg;
    assign m_frame_last = m_last_reg;

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            sem_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = sem_pkg::BK_GRAD;
                end
            end
            sem_pkg::BK_GRAD: begin
                state_next = cur_reg.have ? sem_pkg::BK_SQ : sem_pkg::BK_IDLE;
            end
            sem_pkg::BK_SQ: begin
                state_next = sem_pkg::BK_SUM;
            end
            sem_pkg::BK_SUM: begin
                state_next = sem_pkg::BK_ROOT;
            end
            sem_pkg::BK_ROOT: begin
                if (step_reg == '0) begin
                    state_next = sem_pkg::BK_OUT;
                end
            end
            sem_pkg::BK_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = sem_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = sem_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sem_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // line stores: read at pop, written back in the following cycle
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            up2_reg <= bank0[q_data.col];
            up1_reg <= bank1[q_data.col];
        end
        if (state_reg == sem_pkg::BK_GRAD) begin
            bank0[cur_reg.col] <= up1_reg;
            bank1[cur_reg.col] <= cur_reg.pix;
        end
    end

    always_comb begin
        new_col[0] = up2_reg;
        new_col[1] = up1_reg;
        new_col[2] = cur_reg.pix;
        for (int i = 0; i < 3; i++) begin
            sh[i][0] = win_reg[i][1];
            sh[i][1] = win_reg[i][2];
            sh[i][2] = cur_reg.col_zero ? '0 : new_col[i];
        end
        for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if ((i == 0 && !cur_reg.top_ok) || (i == 2 && !cur_reg.bot_ok)) begin
                        p[ch][i][j] = '0;
                    end else begin
                        p[ch][i][j] = sh[i][j][ch*sem_pkg::CH_W +: sem_pkg::CH_W];
                    end
                end
            end
            pos_x[ch] = {2'b00, p[ch][0][2]} + {1'b0, p[ch][1][2], 1'b0} + {2'b00, p[ch][2][2]};
            neg_x[ch] = {2'b00, p[ch][0][0]} + {1'b0, p[ch][1][0], 1'b0} + {2'b00, p[ch][2][0]};
            pos_y[ch] = {2'b00, p[ch][2][0]} + {1'b0, p[ch][2][1], 1'b0} + {2'b00, p[ch][2][2]};
            neg_y[ch] = {2'b00, p[ch][0][0]} + {1'b0, p[ch][0][1], 1'b0} + {2'b00, p[ch][0][2]};

            // one bit of the rounded root per step: largest k with k*k - k < n
            trial[ch]    = root_reg[ch] | (sem_pkg::CH_W'(1) << step_reg);
            trial_sq[ch] = (2*sem_pkg::CH_W)'(trial[ch]) * (2*sem_pkg::CH_W)'(trial[ch]) -
                           (2*sem_pkg::CH_W)'(trial[ch]);
            root_next[ch] = (sem_pkg::MAG_W'(trial_sq[ch]) < n_reg[ch]) ?
                            trial[ch] : root_reg[ch];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (cfg_clear) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (state_reg == sem_pkg::BK_GRAD) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= cur_reg.col_zero ? '0 : sh[i][0];
                win_reg[i][1] <= cur_reg.col_zero ? '0 : sh[i][1];
                win_reg[i][2] <= new_col[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
            case (state_reg)
                sem_pkg::BK_GRAD: begin
                    ax_reg[ch] <= (pos_x[ch] > neg_x[ch]) ? pos_x[ch] - neg_x[ch]
                                                          : neg_x[ch] - pos_x[ch];
                    ay_reg[ch] <= (pos_y[ch] > neg_y[ch]) ? pos_y[ch] - neg_y[ch]
                                                          : neg_y[ch] - pos_y[ch];
                end
                sem_pkg::BK_SQ: begin
                    sqx_reg[ch] <= sem_pkg::SQ_W'(ax_reg[ch]) * sem_pkg::SQ_W'(ax_reg[ch]);
                    sqy_reg[ch] <= sem_pkg::SQ_W'(ay_reg[ch]) * sem_pkg::SQ_W'(ay_reg[ch]);
                end
                sem_pkg::BK_SUM: begin
                    n_reg[ch]    <= sem_pkg::MAG_W'(sqx_reg[ch]) + sem_pkg::MAG_W'(sqy_reg[ch]);
                    root_reg[ch] <= '0;
                end
                sem_pkg::BK_ROOT: begin
                    root_reg[ch] <= root_next[ch];
                end
                default: begin
                end
            endcase
        end
        if (state_reg == sem_pkg::BK_SUM) begin
            step_reg <= sem_pkg::ROOT_STEP_W'(sem_pkg::CH_W - 1);
        end else if (state_reg == sem_pkg::BK_ROOT) begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_blue_reg  <= root_reg[0];
            m_green_reg <= root_reg[1];
            m_red_reg   <= root_reg[2];
            m_last_reg  <= cur_reg.last;
        end
    end

    a_grad_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sem_pkg::BK_GRAD |-> $past(q_pop))
        else $error("gradient step without a popped slot");

    a_out_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sem_pkg::BK_OUT |-> cur_reg.have)
        else $error("result delivered for a slot without one");

    a_root_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sem_pkg::BK_ROOT && step_reg == '0) |=> state_reg == sem_pkg::BK_OUT)
        else $error("root iteration did not finish after its last bit");

endmodule
